FILE: design/masked_depth_backprojection_core_defines.svh
// ----------------------------------------------------------------------------
// Masked depth back-projection: assertion macros
// Shared property wrappers, clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef MASKED_DEPTH_BACKPROJECTION_CORE_DEFINES_SVH
`define MASKED_DEPTH_BACKPROJECTION_CORE_DEFINES_SVH

// Same-cycle implication.
`define MDBP_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mdbp check failed");

// Implication with a delay between antecedent and consequent.
`define MDBP_ASSERT_DLY4(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##4 (cons)) \
		else $error("mdbp check failed");

`endif

FILE: design/mdbp_pkg.sv
// ----------------------------------------------------------------------------
// Masked depth back-projection package
// Word types, register indexes, reset values and fixed widths.
// ----------------------------------------------------------------------------
package mdbp_pkg;

	localparam int PIX_COORD_W = 12;
	localparam int DEPTH_W     = 16;
	localparam int MASK_W      = 8;
	localparam int POINT_W     = 24;
	localparam int CENTER_W    = 16;
	localparam int INV_W       = 24;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 24;

	// 4 fraction bits from the 1/16 pixel offset plus 24 from the reciprocal
	localparam int RND_SHIFT   = 28;
	localparam int PROD_W      = CENTER_W + DEPTH_W + INV_W;

	localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_INV_FX   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_INV_FY   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_RNG  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_RNG  = 3'd5;

	localparam logic [CENTER_W-1:0] RST_CENTER_X = 16'd5120;
	localparam logic [CENTER_W-1:0] RST_CENTER_Y = 16'd3840;
	localparam logic [INV_W-1:0]    RST_INV_FX   = 24'd27962;
	localparam logic [INV_W-1:0]    RST_INV_FY   = 24'd27962;
	localparam logic [DEPTH_W-1:0]  RST_MIN_RNG  = 16'd100;
	localparam logic [DEPTH_W-1:0]  RST_MAX_RNG  = 16'd3000;

	typedef struct packed {
		logic [PIX_COORD_W-1:0] pixel_col;
		logic [PIX_COORD_W-1:0] pixel_row;
		logic [DEPTH_W-1:0]     depth_mm;
		logic [MASK_W-1:0]      mask_value;
		logic                   frame_end;
	} pixel_in_t;

	typedef struct packed {
		logic                      point_kept;
		logic signed [POINT_W-1:0] point_x_mm;
		logic signed [POINT_W-1:0] point_y_mm;
		logic [DEPTH_W-1:0]        point_z_mm;
		logic                      frame_end_out;
	} point_out_t;

endpackage

FILE: design/mdbp_axis.sv
// ----------------------------------------------------------------------------
// Masked depth back-projection: one axis
// Four-stage pipeline: offset magnitude, times depth, times reciprocal focal
// length, then round half away from zero and saturate to 24-bit signed.
// ----------------------------------------------------------------------------
module mdbp_axis #(
	parameter int CoordW = 12
) (
	input  logic                                 clk,
	input  logic [CoordW-1:0]                    coord,
	input  logic [mdbp_pkg::CENTER_W-1:0]        center,
	input  logic [mdbp_pkg::DEPTH_W-1:0]         depth,
	input  logic [mdbp_pkg::INV_W-1:0]           inv_focal,
	output logic signed [mdbp_pkg::POINT_W-1:0]  coord_mm_s4
);

	localparam int CW  = mdbp_pkg::CENTER_W;
	localparam int MZW = mdbp_pkg::CENTER_W + mdbp_pkg::DEPTH_W;
	localparam int PW  = mdbp_pkg::PROD_W;
	localparam int RW  = PW + 1 - mdbp_pkg::RND_SHIFT;
	localparam int OW  = mdbp_pkg::POINT_W;

	localparam logic [PW:0]   RND_HALF = (PW + 1)'(1) << (mdbp_pkg::RND_SHIFT - 1);
	localparam logic [RW-1:0] POS_MAX  = RW'((1 << (OW - 1)) - 1);
	localparam logic [RW-1:0] NEG_MAG  = RW'(1 << (OW - 1));

	logic [CW-1:0]              pos;
	logic                       neg;
	logic [CW-1:0]              mag;
	logic                       neg_s1, neg_s2, neg_s3;
	logic [CW-1:0]              mag_s1;
	logic [mdbp_pkg::DEPTH_W-1:0] z_s1;
	logic [MZW-1:0]             mz_s2;
	logic [PW-1:0]              prod_s3;
	logic [PW:0]                rsum;
	logic [RW-1:0]              r;
	logic [RW-1:0]              r_sat;
	logic [OW-1:0]              coord_mm;

	assign pos = CW'({coord, 4'b0000});
	assign neg = pos < center;
	assign mag = neg ? (center - pos) : (pos - center);

	assign rsum  = {1'b0, prod_s3} + RND_HALF;
	assign r     = rsum[PW:mdbp_pkg::RND_SHIFT];

	always_comb begin
		if (neg_s3) begin
			r_sat    = (r > NEG_MAG) ? NEG_MAG : r;
			coord_mm = ~r_sat[OW-1:0] + OW'(1);
		end else begin
			r_sat    = (r > POS_MAX) ? POS_MAX : r;
			coord_mm = r_sat[OW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		neg_s1      <= neg;
		mag_s1      <= mag;
		z_s1        <= depth;
		neg_s2      <= neg_s1;
		mz_s2       <= MZW'(mag_s1) * MZW'(z_s1);
		neg_s3      <= neg_s2;
		prod_s3     <= PW'(mz_s2) * PW'(inv_focal);
		coord_mm_s4 <= coord_mm;
	end

endmodule

FILE: design/masked_depth_backprojection_core.sv
// ----------------------------------------------------------------------------
// Masked depth back-projection core
// Keeps masked pixels inside the depth window and back-projects them to
// camera-space millimetres with the pinhole model.
// ----------------------------------------------------------------------------
//  channel  | signals                               | handshake
//  ---------+---------------------------------------+---------------------------
//  pixel in | start, busy, pixel                    | taken when start && !busy
//  point out| result_valid, result                  | one-cycle strobe, no stall
//  config   | cfg_we, cfg_index, cfg_wdata          | written when cfg_we
//
// One word enters per cycle; busy stays low. A result leaves once its pixel has
// passed the two-multiplier axis pipeline (offset, times depth, times reciprocal,
// round and saturate). Every pixel yields one result. Reset clears the valid
// pipeline and loads the register defaults.
// The receiver cannot stall, so nothing ever holds the pipeline.
// ----------------------------------------------------------------------------
module masked_depth_backprojection_core #(
	parameter int COORD_BITS = 12
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  mdbp_pkg::pixel_in_t                pixel,
	output logic                               result_valid,
	output mdbp_pkg::point_out_t               result,
	input  logic                               cfg_we,
	input  logic [mdbp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [mdbp_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

	localparam int UBITS = (COORD_BITS < mdbp_pkg::PIX_COORD_W) ?
		COORD_BITS : mdbp_pkg::PIX_COORD_W;
	localparam int DW = mdbp_pkg::DEPTH_W;
	localparam int OW = mdbp_pkg::POINT_W;

	logic [mdbp_pkg::CENTER_W-1:0] center_x_q, center_y_q;
	logic [mdbp_pkg::INV_W-1:0]    inv_fx_q, inv_fy_q;
	logic [DW-1:0]                 min_rng_q, max_rng_q;

	logic                          accept;
	logic                          kept;
	logic                          valid_s1, valid_s2, valid_s3, valid_s4;
	logic                          kept_s1, kept_s2, kept_s3, kept_s4;
	logic                          fe_s1, fe_s2, fe_s3, fe_s4;
	logic [DW-1:0]                 z_s1, z_s2, z_s3, z_s4;
	logic signed [OW-1:0]          x_s4, y_s4;

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign kept   = (pixel.mask_value != '0) && (pixel.depth_mm >= min_rng_q) &&
		(pixel.depth_mm <= max_rng_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q <= mdbp_pkg::RST_CENTER_X;
			center_y_q <= mdbp_pkg::RST_CENTER_Y;
			inv_fx_q   <= mdbp_pkg::RST_INV_FX;
			inv_fy_q   <= mdbp_pkg::RST_INV_FY;
			min_rng_q  <= mdbp_pkg::RST_MIN_RNG;
			max_rng_q  <= mdbp_pkg::RST_MAX_RNG;
		end else if (cfg_we) begin
			case (cfg_index)
				mdbp_pkg::CFG_CENTER_X: center_x_q <= cfg_wdata[mdbp_pkg::CENTER_W-1:0];
				mdbp_pkg::CFG_CENTER_Y: center_y_q <= cfg_wdata[mdbp_pkg::CENTER_W-1:0];
				mdbp_pkg::CFG_INV_FX:   inv_fx_q   <= cfg_wdata[mdbp_pkg::INV_W-1:0];
				mdbp_pkg::CFG_INV_FY:   inv_fy_q   <= cfg_wdata[mdbp_pkg::INV_W-1:0];
				mdbp_pkg::CFG_MIN_RNG:  min_rng_q  <= cfg_wdata[DW-1:0];
				mdbp_pkg::CFG_MAX_RNG:  max_rng_q  <= cfg_wdata[DW-1:0];
				default: ;  // drop writes to unknown indexes
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		kept_s1 <= kept;
		fe_s1   <= pixel.frame_end;
		z_s1    <= pixel.depth_mm;
		kept_s2 <= kept_s1;
		fe_s2   <= fe_s1;
		z_s2    <= z_s1;
		kept_s3 <= kept_s2;
		fe_s3   <= fe_s2;
		z_s3    <= z_s2;
		kept_s4 <= kept_s3;
		fe_s4   <= fe_s3;
		z_s4    <= z_s3;
	end

	mdbp_axis #(
		.CoordW(UBITS)
	) u_axis_x (
		.clk        (clk),
		.coord      (pixel.pixel_col[UBITS-1:0]),
		.center     (center_x_q),
		.depth      (pixel.depth_mm),
		.inv_focal  (inv_fx_q),
		.coord_mm_s4(x_s4)
	);

	mdbp_axis #(
		.CoordW(UBITS)
	) u_axis_y (
		.clk        (clk),
		.coord      (pixel.pixel_row[UBITS-1:0]),
		.center     (center_y_q),
		.depth      (pixel.depth_mm),
		.inv_focal  (inv_fy_q),
		.coord_mm_s4(y_s4)
	);

	// rejected pixels report zero coordinates but keep the frame flag
	assign result_valid         = valid_s4;
	assign result.point_kept    = kept_s4;
	assign result.point_x_mm    = kept_s4 ? x_s4 : '0;
	assign result.point_y_mm    = kept_s4 ? y_s4 : '0;
	assign result.point_z_mm    = kept_s4 ? z_s4 : '0;
	assign result.frame_end_out = fe_s4;

endmodule

FILE: design/mdbp_checker.sv
// ----------------------------------------------------------------------------
// Masked depth back-projection checker
// Port-level timing and payload checks, bound to the core.
// ----------------------------------------------------------------------------
`include "masked_depth_backprojection_core_defines.svh"

module mdbp_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 start,
	input logic                 busy,
	input mdbp_pkg::pixel_in_t  pixel,
	input logic                 result_valid,
	input mdbp_pkg::point_out_t result
);

	// every taken word comes out later as a valid result
	`MDBP_ASSERT_DLY4(a_latency, start && !busy, result_valid)

	// no result without a matching word taken earlier
	`MDBP_ASSERT_IMP(a_no_phantom, result_valid, $past(start && !busy, 4))

	// a rejected pixel carries an all-zero point
	`MDBP_ASSERT_IMP(a_reject_zero, result_valid && !result.point_kept,
		result.point_x_mm == '0 && result.point_y_mm == '0 && result.point_z_mm == '0)

	// a kept point reports the depth it came in with
	`MDBP_ASSERT_IMP(a_kept_depth, result_valid && result.point_kept,
		result.point_z_mm == $past(pixel.depth_mm, 4))

endmodule

bind masked_depth_backprojection_core mdbp_checker u_mdbp_checker (.*);
